@@ sv/fidg_pkg.sv @@
// Shared constants, tables and types of the FOC inverter duty generator.
package fidg_pkg;

    // CORDIC rotation
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_SPAN  = 38;  // voltage bits plus CORDIC fraction bits
    localparam int XW           = 41;  // CORDIC x/y datapath width, headroom for gain
    localparam int ZW           = 34;  // CORDIC angle residue width

    // Fixed-point scaling
    localparam int PHASE_FRAC = 8;
    localparam int GAIN_SPLIT = 20;    // gain multiply is cut into two partial products

    localparam logic [23:0] CORDIC_GAIN_Q24 = 24'd10188014;
    localparam logic [16:0] SQRT3_Q16       = 17'd113512;

    // Per-step rotation angles as a fraction of one turn (2^32 = one turn)
    localparam logic [31:0] ROT_STEP [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // PWM mode register codes; the remaining code acts as off
    localparam logic [1:0] MODE_SVM  = 2'd0;
    localparam logic [1:0] MODE_SINE = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    // Control that travels with each item down the pipeline
    typedef struct packed {
        logic       vld;
        logic [1:0] mode;
    } t_ctl;

endpackage

@@ sv/fidg_cordic.sv @@
// Quadrant fold and pipelined CORDIC rotation for the inverse Park transform.
module fidg_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int VOLT_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fidg_pkg::t_ctl                    i_ctl,
    input  logic [ANGLE_BITS-1:0]             i_angle,
    input  logic signed [VOLT_BITS-1:0]       i_vd,
    input  logic signed [VOLT_BITS-1:0]       i_vq,
    input  logic [VOLT_BITS-2:0]              i_bus,
    output fidg_pkg::t_ctl                    o_ctl,
    output logic signed [fidg_pkg::XW-1:0]    o_x,
    output logic signed [fidg_pkg::XW-1:0]    o_y,
    output logic [VOLT_BITS-2:0]              o_bus
);
    import fidg_pkg::*;

    localparam int CF = CORDIC_SPAN - VOLT_BITS;

    t_ctl                    r_ctl [CORDIC_STEPS+1];
    logic signed [XW-1:0]    r_x   [CORDIC_STEPS+1];
    logic signed [XW-1:0]    r_y   [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    r_z   [CORDIC_STEPS+1];
    logic [VOLT_BITS-2:0]    r_bus [CORDIC_STEPS+1];

    logic [31:0]             u_raw;
    logic [31:0]             u_fold;
    logic                    fold;
    logic signed [XW-1:0]    x_in;
    logic signed [XW-1:0]    y_in;

    // Fold the angle into -quarter..quarter turn, negating the vector
    always_comb begin
        u_raw  = 32'(i_angle) << (32 - ANGLE_BITS);
        fold   = (u_raw > 32'h4000_0000) && (u_raw < 32'hC000_0000);
        u_fold = fold ? (u_raw - 32'h8000_0000) : u_raw;
        x_in   = XW'(i_vd) <<< CF;
        y_in   = XW'(i_vq) <<< CF;
        if (fold) begin
            x_in = -x_in;
            y_in = -y_in;
        end
    end

    // Entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
        r_x[0]   <= x_in;
        r_y[0]   <= y_in;
        r_z[0]   <= ZW'(signed'(u_fold));
        r_bus[0] <= i_bus;
    end

    // One rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [ZW-1:0] step;
        assign step = signed'(ZW'(ROT_STEP[i]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i+1] <= '0;
            end else begin
                r_ctl[i+1] <= r_ctl[i];
            end
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - step;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + step;
            end
            r_bus[i+1] <= r_bus[i];
        end
    end

    assign o_ctl = r_ctl[CORDIC_STEPS];
    assign o_x   = r_x[CORDIC_STEPS];
    assign o_y   = r_y[CORDIC_STEPS];
    assign o_bus = r_bus[CORDIC_STEPS];

endmodule

@@ sv/fidg_phase.sv @@
// Gain correction, rounding, inverse Clarke and common-mode offset stages.
module fidg_phase #(
    parameter int VOLT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fidg_pkg::t_ctl                    i_ctl,
    input  logic signed [fidg_pkg::XW-1:0]    i_x,
    input  logic signed [fidg_pkg::XW-1:0]    i_y,
    input  logic [VOLT_BITS-2:0]              i_bus,
    output fidg_pkg::t_ctl                    o_ctl,
    output logic signed [VOLT_BITS+12:0]      o_n0,
    output logic signed [VOLT_BITS+12:0]      o_n1,
    output logic signed [VOLT_BITS+12:0]      o_n2,
    output logic [VOLT_BITS-2:0]              o_bus,
    output logic signed [VOLT_BITS:0]         o_alpha,
    output logic signed [VOLT_BITS:0]         o_beta
);
    import fidg_pkg::*;

    localparam int CF  = CORDIC_SPAN - VOLT_BITS;
    localparam int AW  = VOLT_BITS + 10;          // phase-fraction alpha/beta
    localparam int MW  = AW + 19;                 // sqrt3 product and sum
    localparam int PW  = AW + 2;                  // doubled phase voltages
    localparam int HW  = XW - GAIN_SPLIT;
    localparam int LW  = GAIN_SPLIT + 24;
    localparam int SW  = HW + 25 + GAIN_SPLIT;

    localparam logic signed [SW-1:0] RND_G  = SW'(1) <<< 23;
    localparam logic signed [XW-1:0] RND_A  = XW'(1) <<< (CF - PHASE_FRAC - 1);
    localparam logic signed [AW-1:0] RND_8  = AW'(1) <<< (PHASE_FRAC - 1);
    localparam logic signed [MW-1:0] RND_16 = MW'(1) <<< 15;

    t_ctl                       r_ctl [6];
    logic [VOLT_BITS-2:0]       r_bus [6];

    logic signed [HW+24:0]      r1_xh;
    logic signed [HW+24:0]      r1_yh;
    logic [LW-1:0]              r1_xl;
    logic [LW-1:0]              r1_yl;
    logic signed [XW-1:0]       r2_x;
    logic signed [XW-1:0]       r2_y;
    logic signed [AW-1:0]       r3_a;
    logic signed [AW-1:0]       r3_b;
    logic signed [AW-1:0]       r4_a;
    logic signed [AW+17:0]      r4_m;
    logic signed [VOLT_BITS:0]  r4_alpha;
    logic signed [VOLT_BITS:0]  r4_beta;
    logic signed [PW-1:0]       r5_p [3];
    logic signed [VOLT_BITS:0]  r5_alpha;
    logic signed [VOLT_BITS:0]  r5_beta;
    logic signed [PW:0]         r6_n [3];
    logic signed [VOLT_BITS:0]  r6_alpha;
    logic signed [VOLT_BITS:0]  r6_beta;

    logic signed [SW-1:0]       sx;
    logic signed [SW-1:0]       sy;
    logic signed [MW-1:0]       a16;
    logic signed [MW-1:0]       sum1;
    logic signed [MW-1:0]       sum2;
    logic signed [PW-1:0]       pmax;
    logic signed [PW-1:0]       pmin;
    logic signed [PW:0]         mm_sum;
    logic signed [PW-1:0]       off;

    // Control and bus ride along all six stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_ctl[k] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < 6; k++) r_ctl[k] <= r_ctl[k-1];
        end
        r_bus[0] <= i_bus;
        for (int k = 1; k < 6; k++) r_bus[k] <= r_bus[k-1];
    end

    // Stage 1: gain multiply as high and low partial products
    always_ff @(posedge i_clk) begin
        r1_xh <= signed'(i_x[XW-1:GAIN_SPLIT]) * signed'({1'b0, CORDIC_GAIN_Q24});
        r1_yh <= signed'(i_y[XW-1:GAIN_SPLIT]) * signed'({1'b0, CORDIC_GAIN_Q24});
        r1_xl <= i_x[GAIN_SPLIT-1:0] * CORDIC_GAIN_Q24;
        r1_yl <= i_y[GAIN_SPLIT-1:0] * CORDIC_GAIN_Q24;
    end

    // Stage 2: combine partials, round off the Q24 gain
    always_comb begin
        sx = (SW'(r1_xh) <<< GAIN_SPLIT) + signed'(SW'(r1_xl));
        sy = (SW'(r1_yh) <<< GAIN_SPLIT) + signed'(SW'(r1_yl));
    end

    always_ff @(posedge i_clk) begin
        r2_x <= XW'((sx + RND_G) >>> 24);
        r2_y <= XW'((sy + RND_G) >>> 24);
    end

    // Stage 3: round to phase fraction bits
    always_ff @(posedge i_clk) begin
        r3_a <= AW'((r2_x + RND_A) >>> (CF - PHASE_FRAC));
        r3_b <= AW'((r2_y + RND_A) >>> (CF - PHASE_FRAC));
    end

    // Stage 4: sqrt3 product, whole-unit alpha and beta
    always_ff @(posedge i_clk) begin
        r4_a     <= r3_a;
        r4_m     <= r3_b * signed'({1'b0, SQRT3_Q16});
        r4_alpha <= (VOLT_BITS+1)'((r3_a + RND_8) >>> PHASE_FRAC);
        r4_beta  <= (VOLT_BITS+1)'((r3_b + RND_8) >>> PHASE_FRAC);
    end

    // Stage 5: doubled phase voltages (inverse Clarke)
    always_comb begin
        a16  = MW'(r4_a) <<< 16;
        sum1 = -a16 + MW'(r4_m) + RND_16;
        sum2 = -a16 - MW'(r4_m) + RND_16;
    end

    always_ff @(posedge i_clk) begin
        r5_p[0]  <= PW'(r4_a) <<< 1;
        r5_p[1]  <= PW'(sum1 >>> 16);
        r5_p[2]  <= PW'(sum2 >>> 16);
        r5_alpha <= r4_alpha;
        r5_beta  <= r4_beta;
    end

    // Stage 6: min-max common-mode offset in space-vector mode
    always_comb begin
        pmax = r5_p[0];
        pmin = r5_p[0];
        for (int k = 1; k < 3; k++) begin
            if (r5_p[k] > pmax) pmax = r5_p[k];
            if (r5_p[k] < pmin) pmin = r5_p[k];
        end
        mm_sum = (PW+1)'(pmax) + (PW+1)'(pmin);
        off    = (r_ctl[4].mode == MODE_SVM) ? PW'(mm_sum >>> 1) : '0;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) r6_n[k] <= (PW+1)'(r5_p[k]) - (PW+1)'(off);
        r6_alpha <= r5_alpha;
        r6_beta  <= r5_beta;
    end

    assign o_ctl   = r_ctl[5];
    assign o_bus   = r_bus[5];
    assign o_n0    = r6_n[0];
    assign o_n1    = r6_n[1];
    assign o_n2    = r6_n[2];
    assign o_alpha = r6_alpha;
    assign o_beta  = r6_beta;

endmodule

@@ sv/fidg_duty.sv @@
// Duty scaling by the bus voltage: pipelined restoring divider, one bit per stage.
module fidg_duty #(
    parameter int VOLT_BITS = 16,
    parameter int DUTY_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fidg_pkg::t_ctl                    i_ctl,
    input  logic signed [VOLT_BITS+12:0]      i_n0,
    input  logic signed [VOLT_BITS+12:0]      i_n1,
    input  logic signed [VOLT_BITS+12:0]      i_n2,
    input  logic [VOLT_BITS-2:0]              i_bus,
    input  logic signed [VOLT_BITS:0]         i_alpha,
    input  logic signed [VOLT_BITS:0]         i_beta,
    output logic                              o_vld,
    output logic [DUTY_BITS-1:0]              o_duty0,
    output logic [DUTY_BITS-1:0]              o_duty1,
    output logic [DUTY_BITS-1:0]              o_duty2,
    output logic signed [VOLT_BITS:0]         o_alpha,
    output logic signed [VOLT_BITS:0]         o_beta
);
    import fidg_pkg::*;

    localparam int NW = VOLT_BITS + 14;   // bus plus offset phase voltage
    localparam int DW = VOLT_BITS + 8;    // divisor: twice the bus in phase fraction
    localparam int QB = DUTY_BITS + 1;    // quotient bits before the final halving

    logic signed [VOLT_BITS+12:0] n_in [3];

    // Stage D1
    logic                    r1_vld;
    logic                    r1_kill;
    logic signed [NW-1:0]    r1_num [3];
    logic [DW-1:0]           r1_d;
    logic signed [VOLT_BITS:0] r1_alpha;
    logic signed [VOLT_BITS:0] r1_beta;

    // Divider stages, index 0 is the setup stage
    logic                    r_vld   [QB+1];
    logic [DW-1:0]           r_d     [QB+1];
    logic [DW-1:0]           r_rem   [QB+1][3];
    logic [QB-1:0]           r_q     [QB+1][3];
    logic                    r_zero  [QB+1][3];
    logic                    r_sat   [QB+1][3];
    logic signed [VOLT_BITS:0] r_alpha [QB+1];
    logic signed [VOLT_BITS:0] r_beta  [QB+1];

    // Final stage
    logic                    r_out_vld;
    logic [DUTY_BITS-1:0]    r_duty [3];
    logic signed [VOLT_BITS:0] r_out_alpha;
    logic signed [VOLT_BITS:0] r_out_beta;

    assign n_in[0] = i_n0;
    assign n_in[1] = i_n1;
    assign n_in[2] = i_n2;

    // D1: add the bus, note items that give zero duties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_ctl.vld;
        end
        for (int k = 0; k < 3; k++) begin
            r1_num[k] <= NW'(n_in[k]) + signed'(NW'({i_bus, {PHASE_FRAC{1'b0}}}));
        end
        r1_d     <= {i_bus, {(PHASE_FRAC+1){1'b0}}};
        r1_kill  <= (i_bus == '0) || (i_ctl.mode != MODE_SVM && i_ctl.mode != MODE_SINE);
        r1_alpha <= i_alpha;
        r1_beta  <= i_beta;
    end

    // D2: classify each lane and load the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r1_vld;
        end
        for (int k = 0; k < 3; k++) begin
            r_zero[0][k] <= r1_kill || (r1_num[k] <= 0);
            r_sat[0][k]  <= r1_num[k] >= signed'(NW'(r1_d));
            r_rem[0][k]  <= DW'(r1_num[k]);
            r_q[0][k]    <= '0;
        end
        r_d[0]     <= r1_d;
        r_alpha[0] <= r1_alpha;
        r_beta[0]  <= r1_beta;
    end

    // One quotient bit per stage
    for (genvar s = 0; s < QB; s++) begin : g_div
        logic [DW:0] t     [3];
        logic        ge    [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                t[k]  = {r_rem[s][k], 1'b0};
                ge[k] = t[k] >= {1'b0, r_d[s]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            for (int k = 0; k < 3; k++) begin
                r_rem[s+1][k]  <= ge[k] ? DW'(t[k] - {1'b0, r_d[s]}) : DW'(t[k]);
                r_q[s+1][k]    <= {r_q[s][k][QB-2:0], ge[k]};
                r_zero[s+1][k] <= r_zero[s][k];
                r_sat[s+1][k]  <= r_sat[s][k];
            end
            r_d[s+1]     <= r_d[s];
            r_alpha[s+1] <= r_alpha[s];
            r_beta[s+1]  <= r_beta[s];
        end
    end

    // Final: round the Q17 ratio to Q16 and saturate
    logic [QB:0] q_inc [3];

    always_comb begin
        for (int k = 0; k < 3; k++) q_inc[k] = (QB+1)'(r_q[QB][k]) + (QB+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[QB];
        end
        for (int k = 0; k < 3; k++) begin
            if (r_zero[QB][k]) begin
                r_duty[k] <= '0;
            end else if (r_sat[QB][k] || q_inc[k][QB]) begin
                r_duty[k] <= '1;
            end else begin
                r_duty[k] <= q_inc[k][DUTY_BITS:1];
            end
        end
        r_out_alpha <= r_alpha[QB];
        r_out_beta  <= r_beta[QB];
    end

    assign o_vld   = r_out_vld;
    assign o_duty0 = r_duty[0];
    assign o_duty1 = r_duty[1];
    assign o_duty2 = r_duty[2];
    assign o_alpha = r_out_alpha;
    assign o_beta  = r_out_beta;

endmodule

@@ sv/foc_inverter_duty_generator_top.sv @@
// Top level of the FOC inverter duty generator: mode register and pipeline.
//
// Usage:
//   Raise start with one update (angle, Vd, Vq, bus voltage) on the i_ ports.
//   The update is taken at any clock edge with start high and busy low; busy
//   stays low, so a new update can be issued on every clock.
//   Each result (three duties, alpha, beta) is shown for one cycle with
//   o_strobe high at the end of the path. The path is 51 register
//   stages: quadrant fold, 24 CORDIC rotations, 6 gain/Clarke/offset stages,
//   2 setup stages, a 17-stage one-bit-per-stage divider and the output stage.
//   Throughput is one update per clock.
//   The receiver cannot stall; results leave in the order the updates came.
//   The PWM mode register is written over the cfg channel (always ready); the user
//   must write it only while no update is in flight, as the block does not enforce this.
//   Reset (synchronous, active low) clears all in-flight items and sets
//   the mode to space vector.
module foc_inverter_duty_generator_top #(
    parameter int ANGLE_BITS = 16,
    parameter int VOLT_BITS  = 16,
    parameter int DUTY_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ANGLE_BITS-1:0]         i_rotor_angle,
    input  logic signed [VOLT_BITS-1:0]   i_direct_voltage,
    input  logic signed [VOLT_BITS-1:0]   i_quadrature_voltage,
    input  logic [VOLT_BITS-2:0]          i_supply_voltage,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_data,
    output logic                          o_strobe,
    output logic [DUTY_BITS-1:0]          o_duty_u,
    output logic [DUTY_BITS-1:0]          o_duty_v,
    output logic [DUTY_BITS-1:0]          o_duty_w,
    output logic signed [VOLT_BITS:0]     o_alpha_voltage,
    output logic signed [VOLT_BITS:0]     o_beta_voltage
);
    import fidg_pkg::*;

    localparam int LATENCY = 51;

    logic [1:0]              r_pwm_mode;
    t_ctl                    in_ctl;
    t_ctl                    cor_ctl;
    t_ctl                    ph_ctl;
    logic signed [XW-1:0]    cor_x;
    logic signed [XW-1:0]    cor_y;
    logic [VOLT_BITS-2:0]    cor_bus;
    logic [VOLT_BITS-2:0]    ph_bus;
    logic signed [VOLT_BITS+12:0] ph_n0;
    logic signed [VOLT_BITS+12:0] ph_n1;
    logic signed [VOLT_BITS+12:0] ph_n2;
    logic signed [VOLT_BITS:0]    ph_alpha;
    logic signed [VOLT_BITS:0]    ph_beta;

    // Mode register, written by a cfg transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_mode <= MODE_SVM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pwm_mode <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // Every start transfer enters the pipeline with the current mode
    always_comb begin
        in_ctl.vld  = start && !busy;
        in_ctl.mode = r_pwm_mode;
    end

    fidg_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .VOLT_BITS  (VOLT_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_angle (i_rotor_angle),
        .i_vd    (i_direct_voltage),
        .i_vq    (i_quadrature_voltage),
        .i_bus   (i_supply_voltage),
        .o_ctl   (cor_ctl),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_bus   (cor_bus)
    );

    fidg_phase #(
        .VOLT_BITS (VOLT_BITS)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cor_ctl),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .i_bus   (cor_bus),
        .o_ctl   (ph_ctl),
        .o_n0    (ph_n0),
        .o_n1    (ph_n1),
        .o_n2    (ph_n2),
        .o_bus   (ph_bus),
        .o_alpha (ph_alpha),
        .o_beta  (ph_beta)
    );

    fidg_duty #(
        .VOLT_BITS (VOLT_BITS),
        .DUTY_BITS (DUTY_BITS)
    ) u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ph_ctl),
        .i_n0    (ph_n0),
        .i_n1    (ph_n1),
        .i_n2    (ph_n2),
        .i_bus   (ph_bus),
        .i_alpha (ph_alpha),
        .i_beta  (ph_beta),
        .o_vld   (o_strobe),
        .o_duty0 (o_duty_u),
        .o_duty1 (o_duty_v),
        .o_duty2 (o_duty_w),
        .o_alpha (o_alpha_voltage),
        .o_beta  (o_beta_voltage)
    );

`ifndef NO_ASSERTIONS
    // Every accepted update yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("accepted update produced no result");

    // No result without an update accepted the fixed latency earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result strobe without a matching update");
`endif

endmodule

@@ tb/sv/foc_inverter_duty_generator_top_tb.sv @@
// Self-checking testbench for the FOC inverter duty generator top level.
`timescale 1ns / 1ps

module foc_inverter_duty_generator_top_tb;
    import fidg_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;  // spare code, behaves as off
    localparam int         LATENCY     = 51;

    // One result of the block
    typedef struct packed {
        logic [15:0]        duty_u;
        logic [15:0]        duty_v;
        logic [15:0]        duty_w;
        logic signed [16:0] alpha;
        logic signed [16:0] beta;
    } t_duty_set;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        i_rotor_angle;
    logic signed [15:0] i_direct_voltage;
    logic signed [15:0] i_quadrature_voltage;
    logic [14:0]        i_supply_voltage;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_data;
    logic               o_strobe;
    logic [15:0]        o_duty_u;
    logic [15:0]        o_duty_v;
    logic [15:0]        o_duty_w;
    logic signed [16:0] o_alpha_voltage;
    logic signed [16:0] o_beta_voltage;

    // Shadow of the mode register and the store of expected duty sets
    logic [1:0] mode_shadow;
    t_duty_set  pending_duties[$];
    int         error_count;
    int         updates_sent;
    int         results_checked;
    int         send_idle_pct;

    foc_inverter_duty_generator_top dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_rotor_angle        (i_rotor_angle),
        .i_direct_voltage     (i_direct_voltage),
        .i_quadrature_voltage (i_quadrature_voltage),
        .i_supply_voltage     (i_supply_voltage),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .o_strobe             (o_strobe),
        .o_duty_u             (o_duty_u),
        .o_duty_v             (o_duty_v),
        .o_duty_w             (o_duty_w),
        .o_alpha_voltage      (o_alpha_voltage),
        .o_beta_voltage       (o_beta_voltage)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Round half up by a right shift of n bits
    function automatic longint round_up_shr(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // Duty from a doubled, offset phase voltage and the bus in Q8
    function automatic logic [15:0] phase_duty(longint n, longint bus8);
        longint num;
        longint q;
        num = bus8 + n;
        if (num <= 0) return 16'd0;
        q = ((num <<< 16) + bus8) / (2 * bus8);
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    // Inverse Park by CORDIC, then SVM / sine / off duty generation
    function automatic t_duty_set predict_duties(logic [15:0] ang, logic signed [15:0] vd,
                                                 logic signed [15:0] vq, logic [14:0] bus,
                                                 logic [1:0] mode);
        t_duty_set r;
        longint    x, y, z, dx, dy, a8, b8, pmax, pmin, off, bus8, al, be;
        longint    p[3];
        logic [31:0] u;
        x = longint'(vd) * 64'sd4194304;
        y = longint'(vq) * 64'sd4194304;
        u = {ang, 16'h0000};
        // fold the left half-plane by a half-turn rotation
        if (u > 32'h4000_0000 && u < 32'hC000_0000) begin
            x = -x;
            y = -y;
            u = u - 32'h8000_0000;
        end
        z = longint'(signed'(u));
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ROT_STEP[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ROT_STEP[i]);
            end
        end
        x  = round_up_shr(x * longint'(CORDIC_GAIN_Q24), 24);
        y  = round_up_shr(y * longint'(CORDIC_GAIN_Q24), 24);
        a8 = round_up_shr(x, 22 - PHASE_FRAC);
        b8 = round_up_shr(y, 22 - PHASE_FRAC);
        p[0] = 2 * a8;
        p[1] = round_up_shr(-a8 * 65536 + longint'(SQRT3_Q16) * b8, 16);
        p[2] = round_up_shr(-a8 * 65536 - longint'(SQRT3_Q16) * b8, 16);
        r = '0;
        if (bus != 0 && (mode == MODE_SVM || mode == MODE_SINE)) begin
            bus8 = longint'(bus) * 256;
            off  = 0;
            // min-max common-mode injection
            if (mode == MODE_SVM) begin
                pmax = p[0];
                pmin = p[0];
                for (int i = 1; i < 3; i++) begin
                    if (p[i] > pmax) pmax = p[i];
                    if (p[i] < pmin) pmin = p[i];
                end
                off = (pmax + pmin) >>> 1;
            end
            r.duty_u = phase_duty(p[0] - off, bus8);
            r.duty_v = phase_duty(p[1] - off, bus8);
            r.duty_w = phase_duty(p[2] - off, bus8);
        end
        al = round_up_shr(a8, PHASE_FRAC);
        be = round_up_shr(b8, PHASE_FRAC);
        r.alpha = al[16:0];
        r.beta  = be[16:0];
        return r;
    endfunction

    task automatic check_field(string name, longint expd, longint act);
        if (expd != act) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expd, act);
            error_count++;
        end
    endtask

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_duty_set exp_set;
        if (i_rst_n && o_strobe) begin
            if (pending_duties.size() == 0) begin
                $error("result with no update outstanding");
                error_count++;
            end else begin
                exp_set = pending_duties.pop_front();
                check_field("duty_u", exp_set.duty_u, o_duty_u);
                check_field("duty_v", exp_set.duty_v, o_duty_v);
                check_field("duty_w", exp_set.duty_w, o_duty_w);
                check_field("alpha_voltage", exp_set.alpha, o_alpha_voltage);
                check_field("beta_voltage", exp_set.beta, o_beta_voltage);
                results_checked++;
            end
        end
    end

    // Send one update; at times a random idle gap first, transfer when busy is low
    task automatic send_update(logic [15:0] ang, logic signed [15:0] vd,
                               logic signed [15:0] vq, logic [14:0] bus);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start                = 1'b1;
        i_rotor_angle        = ang;
        i_direct_voltage     = vd;
        i_quadrature_voltage = vq;
        i_supply_voltage     = bus;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        pending_duties.push_back(predict_duties(ang, vd, vq, bus, mode_shadow));
        updates_sent++;
    endtask

    // Hold off until every outstanding result has been checked
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_duties.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mode register write, only with the pipeline empty
    task automatic write_mode(logic [1:0] mode);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = mode;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        mode_shadow = mode;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random update, biased toward saturation edges and special angles
    task automatic send_random_update();
        logic [15:0]        ang;
        logic signed [15:0] vd, vq;
        logic [14:0]        bus;
        case ($urandom_range(9))
            0:       ang = 16'(16'h4000 * $urandom_range(3));
            1:       ang = 16'(16'h4000 * $urandom_range(3) + $urandom_range(2) - 1);
            default: ang = 16'($urandom);
        endcase
        if ($urandom_range(3) == 0) begin
            vd = 16'($urandom);
            vq = 16'($urandom);
        end else begin
            vd = 16'($signed($urandom_range(4000)) - 2000);
            vq = 16'($signed($urandom_range(4000)) - 2000);
        end
        case ($urandom_range(9))
            0:       bus = 15'd0;
            1:       bus = 15'($urandom);
            2:       bus = 15'($urandom_range(1, 16));
            default: bus = 15'($urandom_range(1000, 5000));
        endcase
        send_update(ang, vd, vq, bus);
    endtask

    task automatic test_directed(logic [1:0] mode);
        logic [15:0] angles[5] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
        write_mode(mode);
        foreach (angles[i]) send_update(angles[i], 16'sh7FFF, 16'sh8000, 15'h7FFF);
        send_update(16'h2AAA, 16'sh8000, 16'sh7FFF, 15'd1);       // deep saturation
        send_update(16'h1234, 16'sd0, 16'sd0, 15'd3000);          // zero vector
        send_update(16'h5555, 16'sd1500, -16'sd700, 15'd0);       // zero bus
        send_update(16'h8000, 16'sd1000, 16'sd0, 15'd2000);       // angle of pi
        send_update(16'hAAAA, -16'sd1, 16'sh7FFF, 15'h4000);
    endtask

    task automatic test_random(int count, int idle_pct);
        logic [1:0] modes[4] = '{MODE_SVM, MODE_SINE, MODE_OFF, MODE_UNUSED};
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++) begin
            // change mode now and then, mostly the active ones
            if (i % 100 == 0)
                write_mode(($urandom_range(7) == 0) ? modes[$urandom_range(2, 3)]
                                                    : modes[$urandom_range(1)]);
            send_random_update();
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        start                = 1'b0;
        i_rotor_angle        = '0;
        i_direct_voltage     = '0;
        i_quadrature_voltage = '0;
        i_supply_voltage     = '0;
        i_cfg_valid          = 1'b0;
        i_cfg_data           = MODE_SVM;
        mode_shadow          = MODE_SVM;
        error_count          = 0;
        updates_sent         = 0;
        results_checked      = 0;
        send_idle_pct        = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset mode is space vector; one update before any write
        send_update(16'h1000, 16'sd2000, 16'sd500, 15'd4000);
        test_directed(MODE_SVM);
        test_directed(MODE_SINE);
        test_directed(MODE_OFF);
        test_directed(MODE_UNUSED);
        test_random(503, 6);
        test_random(503, 73);
        wait_drained();
        test_random(503, 0);

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d updates, %0d results checked, all four mode codes,",
                 updates_sent, results_checked);
        $display("zero/tiny/full bus, quadrant boundary angles and full-scale voltages.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fidg_pkg.sv
sv/fidg_cordic.sv
sv/fidg_phase.sv
sv/fidg_duty.sv
sv/foc_inverter_duty_generator_top.sv
tb/sv/foc_inverter_duty_generator_top_tb.sv
